/* rtl/buq_pkg.sv */
// ----------------------------------------------------------------------------
// buq_pkg: shared types for the buffered UART byte queues
// Operation codes, beat payloads, controller states and command bundle.
// ----------------------------------------------------------------------------
package buq_pkg;

  localparam int DEPTH_DEF = 512;

  // empty ready events in a row that shut the transmit interrupt off
  localparam logic [1:0] STALL_MAX = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_RECV  = 2'd2,
    OP_READY = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] line_byte;
    logic       line_valid;
    logic       rx_empty;
    logic       tx_empty;
    logic [7:0] rx_overflows;
    logic [7:0] tx_overflows;
    logic       tx_irq_on;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_FIN  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic load;    // capture the input beat
    logic exec;    // update pointers, write or read a queue word
    logic finish;  // assemble the result register
  } cmd_t;

endpackage

/* rtl/buq_ctrl.sv */
// ----------------------------------------------------------------------------
// buq_ctrl: sequencing controller
// Walks each beat through capture, execute, result assembly and delivery.
// ----------------------------------------------------------------------------
module buq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output buq_pkg::cmd_t cmd
);

  buq_pkg::state_t state_r;
  buq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= buq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      buq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = buq_pkg::ST_EXEC;
        end
      end
      buq_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = buq_pkg::ST_FIN;
      end
      buq_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = buq_pkg::ST_OUT;
      end
      buq_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = buq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = buq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/buq_dp.sv */
// ----------------------------------------------------------------------------
// buq_dp: queue datapath
// Two ring memories with head/tail pointers, drop counters, interrupt
// enable with stall counter, and the result register.
// ----------------------------------------------------------------------------
module buq_dp #(
  parameter int DEPTH = buq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  buq_pkg::cmd_t      cmd,
  input  buq_pkg::in_beat_t  in_data,
  output buq_pkg::out_beat_t out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [7:0] tx_mem [DEPTH];
  logic [7:0] rx_mem [DEPTH];

  buq_pkg::op_t       op_r;
  logic [7:0]         data_r;
  logic [PW-1:0]      tx_head_r, tx_tail_r, rx_head_r, rx_tail_r;
  logic [7:0]         tx_drop_r, rx_drop_r;
  logic               irq_r;
  logic [1:0]         stall_r;
  logic [7:0]         tx_rd_r, rx_rd_r;
  logic               rv_pend_r, lv_pend_r;
  buq_pkg::out_beat_t res_r;

  logic [PW-1:0] tx_head_inc, tx_tail_inc, rx_head_inc, rx_tail_inc;
  logic          tx_empty, rx_empty, tx_full, rx_full;
  logic [1:0]    stall_inc;
  logic          tx_push, rx_push, tx_pop, rx_pop;

  always_comb begin
    tx_head_inc = (tx_head_r == LAST) ? '0 : tx_head_r + PW'(1);
    tx_tail_inc = (tx_tail_r == LAST) ? '0 : tx_tail_r + PW'(1);
    rx_head_inc = (rx_head_r == LAST) ? '0 : rx_head_r + PW'(1);
    rx_tail_inc = (rx_tail_r == LAST) ? '0 : rx_tail_r + PW'(1);
    tx_empty    = (tx_head_r == tx_tail_r);
    rx_empty    = (rx_head_r == rx_tail_r);
    tx_full     = (tx_tail_inc == tx_head_r);
    rx_full     = (rx_tail_inc == rx_head_r);
    stall_inc   = (stall_r == buq_pkg::STALL_MAX) ? stall_r : stall_r + 2'd1;
    tx_push     = cmd.exec && (op_r == buq_pkg::OP_PUT) && !tx_full;
    rx_push     = cmd.exec && (op_r == buq_pkg::OP_RECV) && !rx_full;
    rx_pop      = cmd.exec && (op_r == buq_pkg::OP_GET) && !rx_empty;
    tx_pop      = cmd.exec && (op_r == buq_pkg::OP_READY) && irq_r && !tx_empty;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tx_push) begin
      tx_mem[tx_tail_r] <= data_r;
    end
    if (tx_pop) begin
      tx_rd_r <= tx_mem[tx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_push) begin
      rx_mem[rx_tail_r] <= data_r;
    end
    if (rx_pop) begin
      rx_rd_r <= rx_mem[rx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.op;
      data_r <= in_data.data_in;
    end
    if (cmd.finish) begin
      res_r.read_data    <= rv_pend_r ? rx_rd_r : 8'd0;
      res_r.read_valid   <= rv_pend_r;
      res_r.line_byte    <= lv_pend_r ? tx_rd_r : 8'd0;
      res_r.line_valid   <= lv_pend_r;
      res_r.rx_empty     <= rx_empty;
      res_r.tx_empty     <= tx_empty;
      res_r.rx_overflows <= rx_drop_r;
      res_r.tx_overflows <= tx_drop_r;
      res_r.tx_irq_on    <= irq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= '0;
      tx_tail_r <= '0;
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_drop_r <= '0;
      rx_drop_r <= '0;
      irq_r     <= 1'b0;
      stall_r   <= '0;
      rv_pend_r <= 1'b0;
      lv_pend_r <= 1'b0;
    end else if (cmd.exec) begin
      rv_pend_r <= rx_pop;
      lv_pend_r <= tx_pop;
      if (tx_push) tx_tail_r <= tx_tail_inc;
      if (rx_push) rx_tail_r <= rx_tail_inc;
      if (rx_pop)  rx_head_r <= rx_head_inc;
      case (op_r)
        buq_pkg::OP_PUT: begin
          if (tx_full) tx_drop_r <= tx_drop_r + 8'd1;
          irq_r <= 1'b1;
        end
        buq_pkg::OP_RECV: begin
          if (rx_full) rx_drop_r <= rx_drop_r + 8'd1;
        end
        buq_pkg::OP_READY: begin
          if (irq_r) begin
            if (!tx_empty) begin
              tx_head_r <= tx_head_inc;
              stall_r   <= '0;
            end else begin
              stall_r <= stall_inc;
              if (stall_inc == buq_pkg::STALL_MAX) irq_r <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data = res_r;

endmodule

/* rtl/buffered_uart_byte_queues.sv */
// ----------------------------------------------------------------------------
// buffered_uart_byte_queues: transmit and receive byte ring queues
// Software put/get and line receive/ready events against two ring queues,
// one result beat per input beat.
// ----------------------------------------------------------------------------
//   channel | ports                          | payload
//   --------+--------------------------------+---------------------
//   input   | in_valid, in_ready, in_data    | buq_pkg::in_beat_t
//   result  | out_valid, out_ready, out_data | buq_pkg::out_beat_t
//
// The result beat becomes valid after its accepted input beat passes the queue
// update with the registered memory read, then result assembly, and stays
// valid until out_ready; the read word has to land before the result register
// is built. No new input beat is taken until the result beat is taken, and
// in_ready is high only while idle.
// Reset (rst_n low, synchronous) empties both queues, clears drop counts,
// the interrupt enable and the stall count; memory contents are untouched.
// A stalled result beat holds its payload until taken.
// ----------------------------------------------------------------------------
module buffered_uart_byte_queues #(
  parameter int DEPTH = buq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  buq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output buq_pkg::out_beat_t out_data
);

  // command bundle from the sequencer to the datapath
  buq_pkg::cmd_t cmd;

  buq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // queues, pointers, counters and the result register
  buq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

/* rtl/buq_checker.sv */
// ----------------------------------------------------------------------------
// buq_port_checks: port-level checks for the byte queues
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module buq_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input buq_pkg::out_beat_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one beat in flight: no second accept right after one
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("input accepted while a beat is in flight");

  // a get and a ready event never both hand over a byte
  a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.read_valid && out_data.line_valid))
    else $error("both pop flags set in one result");

  // a handed-over byte leaves the interrupt on and the read data zero
  a_line_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_valid |-> out_data.tx_irq_on && out_data.read_data == 8'd0)
    else $error("line byte delivered with interrupt off");

endmodule

bind buffered_uart_byte_queues buq_port_checks u_buq_port_checks (.*);
